// ===== rtl/wpft_pkg.sv =====
// Shared constants and types for the wake port filter table.
package wpft_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF      = 64;
  localparam int SCREEN_OFF_SLOTS_DEF = 8;

  // Field widths fixed by the interface
  localparam int PORT_W     = 16;
  localparam int PROTO_W    = 2;
  localparam int FUNC_W     = 3;
  localparam int ACT_W      = 3;
  localparam int PUSH_W     = 7;
  localparam int LIMIT_W    = 7;
  localparam int IDX_W      = 6;
  localparam int SOC_W      = 4;
  localparam int DZC_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int ENTRY_W    = PORT_W + PROTO_W;

  // Saturation of the push count
  localparam int PUSH_MAX = 127;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_HOOK       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEV        = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCREEN_ON  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SCREEN_OFF = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DOZE_ON    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DOZE_OFF   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd6;

  // Push actions
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REPUSH  = 3'd4;

  // Stored protocol codes
  localparam logic [PROTO_W-1:0] PROTO_NONE = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 2'd1;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 2'd2;

  // IP protocol numbers
  localparam logic [7:0] IP_TCP = 8'd6;
  localparam logic [7:0] IP_UDP = 8'd17;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SUP  = 2'd1;

  // Sequencer to scan unit
  typedef struct packed {
    logic go;
  } scan_ctl_t;

  // Scan unit to sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } scan_sts_t;

endpackage

// ===== rtl/wpft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wpft_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wpft_scan.sv =====
// Serial duplicate-port scan: one table read issued and one compare per cycle.
module wpft_scan #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wpft_pkg::scan_ctl_t        ctl,
  input  logic [CW-1:0]              count,
  input  logic [wpft_pkg::PORT_W-1:0] key,
  input  logic [wpft_pkg::PORT_W-1:0] ent_port,
  output logic [AW-1:0]              raddr,
  output wpft_pkg::scan_sts_t        sts
);

  import wpft_pkg::*;

  logic          run;
  logic          pend;
  logic [CW-1:0] idx;
  logic          issue;
  logic          match;

  assign issue = run && (idx < count);
  assign match = pend && (ent_port == key);
  assign raddr = idx[AW-1:0];

  assign sts.hit  = match;
  assign sts.done = run && (match || (!issue && !pend));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pend <= 1'b0;
      idx  <= '0;
    end else if (ctl.go) begin
      run  <= 1'b1;
      pend <= 1'b0;
      idx  <= '0;
    end else if (run) begin
      if (sts.done) begin
        run  <= 1'b0;
        pend <= 1'b0;
      end else begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/wake_port_filter_table_core.sv =====
// Top level of the wake port filter table: sequencer, counters, table and scan unit.
//
//  channel  | handshake                     | beat contents
//  ---------+-------------------------------+------------------------------------------
//  command  | start in, busy out            | func, dest_port, ip_protocol,
//           |                               | from_local_in, from_wlan, entry_index
//  result   | done out (one-cycle strobe)   | added, action, push_count, entry_port,
//           |                               | entry_protocol, screen_off_count, doze_count
//  config   | cfg_valid in, cfg_ready out   | cfg_index, cfg_data
//
// A command beat is taken when start is high and busy is low; busy drops with the result
// strobe. A stored-packet check runs exec, scan, write, post, or drops early; the single
// scan unit compares one counted table entry a cycle against the RAM's registered read.
// Other events strobe from exec, a read from the read state. Reset (rst, synchronous)
// empties the table at once through per-entry valid bits; screen on does the same with
// filter support. Config beats are taken only while idle; results cannot be held off.
module wake_port_filter_table_core #(
  parameter int TABLE_DEPTH      = wpft_pkg::TABLE_DEPTH_DEF,
  parameter int SCREEN_OFF_SLOTS = wpft_pkg::SCREEN_OFF_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command
  input  logic                             start,
  output logic                             busy,
  input  logic [wpft_pkg::FUNC_W-1:0]      func,
  input  logic [wpft_pkg::PORT_W-1:0]      dest_port,
  input  logic [7:0]                       ip_protocol,
  input  logic                             from_local_in,
  input  logic                             from_wlan,
  input  logic [wpft_pkg::IDX_W-1:0]       entry_index,
  // result
  output logic                             done,
  output logic                             added,
  output logic [wpft_pkg::ACT_W-1:0]       action,
  output logic [wpft_pkg::PUSH_W-1:0]      push_count,
  output logic [wpft_pkg::PORT_W-1:0]      entry_port,
  output logic [wpft_pkg::PROTO_W-1:0]     entry_protocol,
  output logic [wpft_pkg::SOC_W-1:0]       screen_off_count,
  output logic [wpft_pkg::DZC_W-1:0]       doze_count,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wpft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wpft_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import wpft_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = $clog2(SCREEN_OFF_SLOTS + 1);
  // Common width for limit, capacity and count arithmetic
  localparam int NW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  logic [2:0] state;

  // Configuration registers
  logic [LIMIT_W-1:0] table_limit;
  logic               filter_sup;

  // Mode flags and region counters
  logic          screen_off;
  logic          doze_on;
  logic [SW-1:0] sof;
  logic [SW-1:0] son;
  logic [CW-1:0] dzf;
  logic [CW-1:0] dzn;

  // Latched command
  logic [FUNC_W-1:0]  func_q;
  logic [PORT_W-1:0]  key;
  logic [PROTO_W-1:0] proto_q;
  logic               local_q;
  logic               wlan_q;
  logic [IDX_W-1:0]   idx_q;

  // Table
  logic [TABLE_DEPTH-1:0] valid;
  logic                   vld_q;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [ENTRY_W-1:0]     rdata;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          scan_addr;
  logic [PORT_W-1:0]      ent_port;
  logic [PROTO_W-1:0]     ent_proto;

  scan_ctl_t scan_ctl;
  scan_sts_t scan_sts;

  // Region arithmetic
  logic [NW-1:0] lim;
  logic [NW-1:0] sof_w;
  logic [NW-1:0] dzf_w;
  logic [NW-1:0] cap;
  logic [NW-1:0] dslot;
  logic [NW-1:0] dnext;
  logic [SW-1:0] sslot;
  logic [SW-1:0] snext;
  logic [NW-1:0] counted;
  logic [NW-1:0] cnt_sat;
  logic [NW-1:0] push_now;
  logic [NW-1:0] idx_w;
  logic          idx_ok;
  logic          pkt_ok;
  logic          use_doze;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  assign sof_w   = NW'(sof);
  assign dzf_w   = NW'(dzf);
  assign lim     = (NW'(table_limit) < NW'(TABLE_DEPTH)) ? NW'(table_limit)
                                                         : NW'(TABLE_DEPTH);
  assign cap     = (lim > sof_w) ? (lim - sof_w) : '0;
  assign dslot   = (NW'(dzn) >= cap) ? '0 : NW'(dzn);
  assign dnext   = dslot + 1'b1;
  assign sslot   = (son >= SW'(SCREEN_OFF_SLOTS)) ? '0 : son;
  assign snext   = sslot + 1'b1;
  assign counted = sof_w + dzf_w;
  assign cnt_sat = (counted < NW'(TABLE_DEPTH)) ? counted : NW'(TABLE_DEPTH);
  assign push_now = (cnt_sat < NW'(PUSH_MAX)) ? cnt_sat : NW'(PUSH_MAX);

  assign idx_w  = NW'(idx_q);
  assign idx_ok = (idx_w < NW'(TABLE_DEPTH));

  assign pkt_ok = ((func_q == FUNC_HOOK) && filter_sup && doze_on && local_q) ||
                  ((func_q == FUNC_DEV) && filter_sup && wlan_q && screen_off);
  assign use_doze = (func_q == FUNC_HOOK) || doze_on;

  // Entries never written since the last clear read as zero
  assign ent_port  = vld_q ? rdata[PORT_W-1:0] : '0;
  assign ent_proto = vld_q ? rdata[ENTRY_W-1:PORT_W] : PROTO_NONE;

  assign raddr = (state == S_EXEC) ? AW'(idx_w) : scan_addr;
  assign we    = (state == S_WRITE);
  assign waddr = use_doze ? AW'(sof_w + dslot) : AW'(sslot);

  assign scan_ctl.go = (state == S_EXEC) && pkt_ok && !(use_doze && (cap == '0));

  // Counts come straight from the live counters
  logic [NW-1:0] dzf_x;
  assign dzf_x            = dzf_w;
  assign screen_off_count = sof_w[SOC_W-1:0];
  assign doze_count       = dzf_x[DZC_W-1:0];

  wpft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({proto_q, key}),
    .raddr (raddr),
    .rdata (rdata)
  );

  wpft_scan #(
    .AW (AW),
    .CW (CW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .count    (CW'(cnt_sat)),
    .key      (key),
    .ent_port (ent_port),
    .raddr    (scan_addr),
    .sts      (scan_sts)
  );

  // Valid bit follows the read address so it lines up with the registered RAM data
  always_ff @(posedge clk) begin
    vld_q <= valid[raddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= LIMIT_W'(TABLE_DEPTH_DEF);
      filter_sup  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TABLE_LIMIT: table_limit <= cfg_data[LIMIT_W-1:0];
        REG_FILTER_SUP:  filter_sup  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_q  <= func;
      local_q <= from_local_in;
      wlan_q  <= from_wlan;
      idx_q   <= entry_index;
      // Non-TCP/UDP packets store port 0 with no protocol
      if (ip_protocol == IP_TCP) begin
        key     <= dest_port;
        proto_q <= PROTO_TCP;
      end else if (ip_protocol == IP_UDP) begin
        key     <= dest_port;
        proto_q <= PROTO_UDP;
      end else begin
        key     <= '0;
        proto_q <= PROTO_NONE;
      end
    end
  end

  // Result payload: set with the strobe, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      S_EXEC: begin
        added          <= 1'b0;
        action         <= ACT_NONE;
        push_count     <= '0;
        entry_port     <= '0;
        entry_protocol <= PROTO_NONE;
        case (func_q)
          FUNC_SCREEN_ON:  if (filter_sup) action <= ACT_DISABLE;
          FUNC_SCREEN_OFF: if (filter_sup) action <= ACT_ENABLE;
          FUNC_DOZE_OFF: begin
            if (filter_sup) begin
              action     <= ACT_REPUSH;
              push_count <= PUSH_W'(sof_w);
            end
          end
          default: ;
        endcase
      end
      S_POST: begin
        added      <= 1'b1;
        action     <= ACT_PUSH;
        push_count <= PUSH_W'(push_now);
      end
      S_READ: begin
        entry_port     <= idx_ok ? ent_port : '0;
        entry_protocol <= idx_ok ? ent_proto : PROTO_NONE;
      end
      default: ;
    endcase
  end

  // Sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      screen_off <= 1'b0;
      doze_on    <= 1'b0;
      sof        <= '0;
      son        <= '0;
      dzf        <= '0;
      dzn        <= '0;
      valid      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (pkt_ok) begin
            // Doze region with no room: drop without scanning
            if (scan_ctl.go) begin
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
              done  <= 1'b1;
            end
          end else if (func_q == FUNC_READ) begin
            state <= S_READ;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
            case (func_q)
              FUNC_SCREEN_ON: begin
                if (filter_sup) begin
                  screen_off <= 1'b0;
                  valid      <= '0;
                  sof        <= '0;
                  son        <= '0;
                  dzf        <= '0;
                  dzn        <= '0;
                end
              end
              FUNC_SCREEN_OFF: if (filter_sup) screen_off <= 1'b1;
              FUNC_DOZE_ON:    doze_on <= 1'b1;
              FUNC_DOZE_OFF: begin
                doze_on <= 1'b0;
                if (filter_sup) begin
                  dzf <= '0;
                  dzn <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_sts.done) begin
            if (scan_sts.hit) begin
              // Port already known: drop
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          state        <= S_POST;
          valid[waddr] <= 1'b1;
          if (use_doze) begin
            if (dnext < cap) begin
              dzn <= CW'(dnext);
              if (dzf_w < cap) begin
                dzf <= CW'(dnext);
              end
            end else begin
              dzf <= CW'(cap);
              dzn <= '0;
            end
          end else begin
            // Ring wraps after the last slot; fill then stays full
            if (snext < SW'(SCREEN_OFF_SLOTS)) begin
              son <= snext;
              if (sof < SW'(SCREEN_OFF_SLOTS)) begin
                sof <= snext;
              end
            end else begin
              sof <= SW'(SCREEN_OFF_SLOTS);
              son <= '0;
            end
          end
        end
        S_POST: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_READ: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
